// ===== sv/emp_pkg.sv =====
// ----------------------------------------------------------------------------
// emp_pkg: shared constants for the ElGamal engine
// Reset values of the configuration registers, register indexes, status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package emp_pkg;
    localparam int WordWidth = 16;
    localparam int CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] REG_PRIME     = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_PRIVATE   = 2'd2;

    localparam int PrimeReset     = 7919;
    localparam int GeneratorReset = 2;
    localparam int PrivateReset   = 1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;
endpackage
`default_nettype wire

// ===== sv/emp_modmul.sv =====
// ----------------------------------------------------------------------------
// emp_modmul: serial modular multiplier
// Computes a*b mod m one bit of b per cycle (shift-add with conditional
// subtract). m is the effective modulus, W+1 bits so 2^W is representable.
// a must be below m (or 1); b may be any W+1 bit value.
// ----------------------------------------------------------------------------
`default_nettype none
module emp_modmul #(
    parameter int W = emp_pkg::WordWidth
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W:0]   a,
    input  wire logic [W:0]   b,
    input  wire logic [W:0]   m,
    output logic              done,
    output logic [W:0]        prod
);
    localparam int CW = $clog2(W + 2);

    logic [W:0]    acc_reg, acc_next;
    logic [W:0]    a_reg, b_reg, m_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W+2:0]  dbl, add;

    always_comb
    begin
        dbl = {2'b00, acc_reg} << 1;
        if (dbl >= {2'b00, m_reg})
        begin
            dbl = dbl - {2'b00, m_reg};
        end
        add = dbl;
        if (b_reg[W])
        begin
            add = dbl + {2'b00, a_reg};
        end
        if (add >= {2'b00, m_reg})
        begin
            add = add - {2'b00, m_reg};
        end
        acc_next = add[W:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                m_reg    <= m;
                cnt_reg  <= CW'(W + 1);
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ===== sv/elgamal_mod_prime_cipher.sv =====
// ----------------------------------------------------------------------------
// elgamal_mod_prime_cipher: ElGamal encrypt / decrypt engine
// Modular exponentiation and decryption search on one serial multiplier.
//
//  channel | direction | signals
//  in      | to block  | in_valid, in_ready, kind, message, nonce, cipher_r, cipher_m
//  out     | from block| out_valid, out_ready, out_r, out_m, plain_out, public_key, status
//  cfg     | to block  | cfg_we, cfg_index, cfg_data
//
// Multiplies run on the shared multiplier. An exponentiation takes up to
// 2*W+1 multiplies (base reduction, then one square and at most one multiply
// per exponent bit). Encrypt runs three exponentiations and one multiply
// (only the first exponentiation if the range check fails); decrypt runs two,
// then searches by running addition, one candidate per cycle, up to p-1 of them.
// Reset clears control; config returns to its reset values.
// in_ready is low while an item is in work or its result waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module elgamal_mod_prime_cipher #(
    parameter int WORD_WIDTH = emp_pkg::WordWidth
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [15:0]                   message,
    input  wire logic [15:0]                   nonce,
    input  wire logic [15:0]                   cipher_r,
    input  wire logic [15:0]                   cipher_m,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [15:0]                        out_r,
    output logic [15:0]                        out_m,
    output logic [15:0]                        plain_out,
    output logic [15:0]                        public_key,
    output logic [1:0]                         status,
    input  wire logic                          cfg_we,
    input  wire logic [emp_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [WORD_WIDTH-1:0]         cfg_data
);
    localparam int W  = WORD_WIDTH;
    localparam int EW = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PUB, S_CHECK, S_SHARED, S_GK, S_MMUL, S_DECPOW,
        S_SEARCH, S_OUT, S_EXP_SQ, S_EXP_WAIT
    } state_t;

    state_t        state_reg, ret_reg;
    logic [W-1:0]  prime_reg, gen_reg, priv_reg;
    logic          kind_reg;
    logic [W-1:0]  msg_reg, nonce_reg, cr_reg, cm_reg;
    logic [W:0]    mod_reg;
    logic [W:0]    pub_reg, shared_reg, r_reg, s_reg, m_out_reg, plain_reg;
    logic [1:0]    status_reg;

    // exponentiation engine state
    logic [W:0]    acc_reg, sq_reg;
    logic [W-1:0]  e_reg;
    logic [EW-1:0] bit_reg;
    logic          phase_reg;          // 0: multiply acc, 1: square
    logic [W:0]    res_reg;

    // search
    logic [W:0]    n_reg, sn_reg;

    // multiplier
    logic          mul_start;
    logic [W:0]    mul_a, mul_b, mul_out;
    logic          mul_done;
    logic [W:0]    mul_a_reg, mul_b_reg;
    logic          mul_go_reg;

    assign mul_start = mul_go_reg;
    assign mul_a = mul_a_reg;
    assign mul_b = mul_b_reg;

    emp_modmul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .m     (mod_reg),
        .done  (mul_done),
        .prod  (mul_out)
    );

    logic [W:0] eff_mod;
    logic [W+1:0] sn_add;
    assign eff_mod = (prime_reg == '0) ? {1'b1, {W{1'b0}}} : {1'b0, prime_reg};
    always_comb
    begin
        sn_add = {1'b0, sn_reg} + {1'b0, s_reg};
        if (sn_add >= {1'b0, mod_reg})
        begin
            sn_add = sn_add - {1'b0, mod_reg};
        end
    end

    logic enc_bad;
    assign enc_bad = ({1'b0, msg_reg} >= mod_reg) || (nonce_reg == '0) ||
                     (mod_reg < (W+1)'(3)) || ({1'b0, nonce_reg} > mod_reg - (W+1)'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            prime_reg  <= W'(emp_pkg::PrimeReset);
            gen_reg    <= W'(emp_pkg::GeneratorReset);
            priv_reg   <= W'(emp_pkg::PrivateReset);
            mul_go_reg <= 1'b0;
            phase_reg  <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            mul_go_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    emp_pkg::REG_PRIME:     prime_reg <= cfg_data;
                    emp_pkg::REG_GENERATOR: gen_reg   <= cfg_data;
                    emp_pkg::REG_PRIVATE:   priv_reg  <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg   <= kind;
                        msg_reg    <= W'(message);
                        nonce_reg  <= W'(nonce);
                        cr_reg     <= W'(cipher_r);
                        cm_reg     <= W'(cipher_m);
                        mod_reg    <= eff_mod;
                        m_out_reg  <= '0;
                        r_reg      <= '0;
                        plain_reg  <= '0;
                        status_reg <= emp_pkg::STATUS_OK;
                        // pub = g^x
                        sq_reg     <= {1'b0, gen_reg};
                        e_reg      <= priv_reg;
                        ret_reg    <= S_PUB;
                        state_reg  <= S_EXP_SQ;
                        phase_reg  <= 1'b0;
                    end
                end
                // reduce base: 1*base mod m with the base shifted in bit by bit
                S_EXP_SQ:
                begin
                    mul_a_reg  <= (W+1)'(1);
                    mul_b_reg  <= sq_reg;
                    mul_go_reg <= 1'b1;
                    acc_reg    <= (W+1)'(1);
                    bit_reg    <= EW'(W);
                    phase_reg  <= 1'b1;
                    state_reg  <= S_EXP_WAIT;
                end
                S_EXP_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (phase_reg)
                        begin
                            sq_reg <= mul_out;
                            if (bit_reg == '0 || e_reg == '0)
                            begin
                                res_reg   <= acc_reg;
                                state_reg <= ret_reg;
                            end
                            else if (e_reg[0])
                            begin
                                mul_a_reg  <= acc_reg;
                                mul_b_reg  <= mul_out;
                                mul_go_reg <= 1'b1;
                                phase_reg  <= 1'b0;
                            end
                            else
                            begin
                                e_reg      <= e_reg >> 1;
                                bit_reg    <= bit_reg - EW'(1);
                                mul_a_reg  <= mul_out;
                                mul_b_reg  <= mul_out;
                                mul_go_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            acc_reg    <= mul_out;
                            e_reg      <= e_reg >> 1;
                            bit_reg    <= bit_reg - EW'(1);
                            mul_a_reg  <= sq_reg;
                            mul_b_reg  <= sq_reg;
                            mul_go_reg <= 1'b1;
                            phase_reg  <= 1'b1;
                        end
                    end
                end
                S_PUB:
                begin
                    pub_reg <= res_reg;
                    if (kind_reg)
                    begin
                        sq_reg    <= {1'b0, cr_reg};
                        e_reg     <= priv_reg;
                        ret_reg   <= S_DECPOW;
                        state_reg <= S_EXP_SQ;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (enc_bad)
                    begin
                        status_reg <= emp_pkg::STATUS_RANGE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        sq_reg    <= pub_reg;
                        e_reg     <= nonce_reg;
                        ret_reg   <= S_SHARED;
                        state_reg <= S_EXP_SQ;
                    end
                end
                S_SHARED:
                begin
                    shared_reg <= res_reg;
                    sq_reg     <= {1'b0, gen_reg};
                    e_reg      <= nonce_reg;
                    ret_reg    <= S_GK;
                    state_reg  <= S_EXP_SQ;
                end
                S_GK:
                begin
                    r_reg      <= res_reg;
                    mul_a_reg  <= {1'b0, msg_reg};
                    mul_b_reg  <= shared_reg;
                    mul_go_reg <= 1'b1;
                    state_reg  <= S_MMUL;
                end
                S_MMUL:
                begin
                    if (mul_done)
                    begin
                        m_out_reg <= mul_out;
                        state_reg <= S_OUT;
                    end
                end
                S_DECPOW:
                begin
                    // s may be 1 unreduced only when m=1; search range is empty then
                    s_reg     <= res_reg;
                    n_reg     <= (W+1)'(1);
                    sn_reg    <= '0;
                    state_reg <= S_SEARCH;
                end
                S_SEARCH:
                begin
                    if (n_reg >= mod_reg)
                    begin
                        status_reg <= emp_pkg::STATUS_NO_MATCH;
                        state_reg  <= S_OUT;
                    end
                    else if (sn_add[W:0] == {1'b0, cm_reg})
                    begin
                        plain_reg <= n_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sn_reg <= sn_add[W:0];
                        n_reg  <= n_reg + (W+1)'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_r      = 16'(r_reg);
    assign out_m      = 16'(m_out_reg);
    assign plain_out  = 16'(plain_reg);
    assign public_key = 16'(pub_reg);
    assign status     = status_reg;

    ap_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    ap_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != emp_pkg::STATUS_OK |-> out_r == '0 && out_m == '0)
        else $error("nonzero cipher on error");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(plain_out))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== test/elgamal_mod_prime_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// elgamal_mod_prime_cipher_tb: self-checking bench for the ElGamal engine
// Drives encrypt and decrypt items through the valid/ready input channel,
// predicts every result from its own copy of the configuration, and checks
// each result field by field. Both sides idle at random; configuration is
// written only while the engine is idle, across small and extreme moduli.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module elgamal_mod_prime_cipher_tb;

    typedef enum logic { KIND_ENCRYPT = 1'b0, KIND_DECRYPT = 1'b1 } kind_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] m;
        logic [15:0] plain;
        logic [15:0] pub;
        logic [1:0]  status;
    } cipher_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [15:0] message = '0;
    logic [15:0] nonce = '0;
    logic [15:0] cipher_r = '0;
    logic [15:0] cipher_m = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_r;
    logic [15:0] out_m;
    logic [15:0] plain_out;
    logic [15:0] public_key;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [emp_pkg::CfgIdxWidth-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [15:0] prime_q = 16'(emp_pkg::PrimeReset);
    logic [15:0] gen_q = 16'(emp_pkg::GeneratorReset);
    logic [15:0] key_q = 16'(emp_pkg::PrivateReset);

    cipher_result_t pending_results[$];
    int errors = 0;
    bit no_idle = 1'b0;

    elgamal_mod_prime_cipher dut (.*);

    always #2 clk = ~clk;

    function automatic longint unsigned modexp(longint unsigned base,
            longint unsigned e, longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq = base % m;
        do begin
            if (e[0])
                acc = (acc * sq) % m;
            e = e >> 1;
            sq = (sq * sq) % m;
        end while (e != 0);
        return acc;
    endfunction

    function automatic cipher_result_t predict_cipher(logic k, logic [15:0] msg,
            logic [15:0] nc, logic [15:0] cr, logic [15:0] cm);
        cipher_result_t res;
        longint unsigned m;
        longint unsigned s;
        longint unsigned n;
        res = '0;
        m = (prime_q == 0) ? 64'd65536 : 64'(prime_q);
        res.pub = 16'(modexp(gen_q, key_q, m));
        if (k == KIND_ENCRYPT) begin
            if (msg >= m || nc == 0 || m < 3 || nc > m - 2)
                res.status = emp_pkg::STATUS_RANGE;
            else begin
                res.r = 16'(modexp(gen_q, nc, m));
                res.m = 16'((64'(msg) * modexp(res.pub, nc, m)) % m);
                res.status = emp_pkg::STATUS_OK;
            end
        end else begin
            s = modexp(cr, key_q, m);
            res.status = emp_pkg::STATUS_NO_MATCH;
            for (n = 1; n < m; n++) begin
                if ((s * n) % m == cm) begin
                    res.plain = 16'(n);
                    res.status = emp_pkg::STATUS_OK;
                    break;
                end
            end
        end
        return res;
    endfunction

    // enter at a rising edge; returns at the edge where the item is accepted
    task automatic send_item(logic k, logic [15:0] msg, logic [15:0] nc,
            logic [15:0] cr, logic [15:0] cm);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        message <= msg;
        nonce <= nc;
        cipher_r <= cr;
        cipher_m <= cm;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        pending_results.push_back(predict_cipher(k, msg, nc, cr, cm));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [emp_pkg::CfgIdxWidth-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            emp_pkg::REG_PRIME:     prime_q = val;
            emp_pkg::REG_GENERATOR: gen_q = val;
            emp_pkg::REG_PRIVATE:   key_q = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] p, logic [15:0] g, logic [15:0] x);
        drain();
        write_cfg(emp_pkg::REG_PRIME, p);
        write_cfg(emp_pkg::REG_GENERATOR, g);
        write_cfg(emp_pkg::REG_PRIVATE, x);
        cfg_we <= 1'b0;
    endtask

    task automatic encrypt_then_decrypt(logic [15:0] msg, logic [15:0] nc);
        cipher_result_t c;
        c = predict_cipher(KIND_ENCRYPT, msg, nc, '0, '0);
        send_item(KIND_ENCRYPT, msg, nc, 16'hAAAA, 16'h5555);
        send_item(KIND_DECRYPT, 16'h5555, 16'hAAAA, c.r, c.m);
    endtask

    task automatic test_reset_config();
        send_item(KIND_ENCRYPT, 16'd0, 16'd1, 16'd0, 16'd0);
        send_item(KIND_ENCRYPT, 16'd7918, 16'd7917, 16'hFFFF, 16'hFFFF);
        encrypt_then_decrypt(16'd1234, 16'd55);
    endtask

    task automatic test_encrypt_range();
        send_item(KIND_ENCRYPT, 16'd7919, 16'd5, 16'd0, 16'd0);
        send_item(KIND_ENCRYPT, 16'd10, 16'd0, 16'd0, 16'd0);
        send_item(KIND_ENCRYPT, 16'd10, 16'd7918, 16'd0, 16'd0);
        send_item(KIND_ENCRYPT, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    endtask

    task automatic test_decrypt_miss();
        send_item(KIND_DECRYPT, 16'd0, 16'd0, 16'd0, 16'd5);
        send_item(KIND_DECRYPT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_modulus_extremes();
        // zero modulus acts as 2^16
        set_config(16'd0, 16'hFFFF, 16'hFFFF);
        send_item(KIND_ENCRYPT, 16'hFFFF, 16'hFFFE, 16'd0, 16'd0);
        send_item(KIND_DECRYPT, 16'd0, 16'd0, 16'd3, 16'hFFFF);
        set_config(16'hFFFF, 16'd2, 16'd3);
        send_item(KIND_DECRYPT, 16'd0, 16'd0, 16'd7, 16'd1000);
        set_config(16'd1, 16'd1, 16'd0);
        send_item(KIND_ENCRYPT, 16'd0, 16'd1, 16'd0, 16'd0);
        send_item(KIND_DECRYPT, 16'd0, 16'd0, 16'd5, 16'd0);
        set_config(16'd2, 16'd1, 16'd5);
        send_item(KIND_ENCRYPT, 16'd1, 16'd1, 16'd0, 16'd0);
        send_item(KIND_DECRYPT, 16'd0, 16'd0, 16'd1, 16'd1);
    endtask

    task automatic test_key_extremes();
        set_config(16'd3, 16'd1, 16'd0);
        encrypt_then_decrypt(16'd2, 16'd1);
        // generator above p-2 and zero generator
        set_config(16'd11, 16'd0, 16'hFFFF);
        encrypt_then_decrypt(16'd7, 16'd9);
        set_config(16'd11, 16'd40000, 16'd7);
        send_item(KIND_ENCRYPT, 16'd3, 16'd4, 16'd0, 16'd0);
    endtask

    task automatic test_random();
        logic [15:0] primes[9] = '{3, 5, 7, 11, 13, 101, 251, 1009, 7919};
        logic [15:0] p;
        cipher_result_t last;
        logic [15:0] msg;
        logic [15:0] nc;
        int sel;
        last = '0;
        for (int phase = 0; phase < 10; phase++) begin
            p = primes[$urandom_range(0, 7 + (phase == 4))];
            set_config(p, 16'($urandom_range(1, p - 2)), 16'($urandom));
            no_idle = (phase % 3 == 2);
            for (int i = 0; i < 10; i++) begin
                sel = $urandom_range(0, 99);
                msg = 16'($urandom_range(0, p - 1));
                nc = 16'($urandom_range(1, p - 2));
                if (sel < 40) begin
                    last = predict_cipher(KIND_ENCRYPT, msg, nc, '0, '0);
                    send_item(KIND_ENCRYPT, msg, nc, 16'($urandom), 16'($urandom));
                end else if (sel < 75) begin
                    send_item(KIND_DECRYPT, 16'($urandom), 16'($urandom), last.r, last.m);
                end else if (sel < 85) begin
                    send_item(KIND_DECRYPT, 16'($urandom), 16'($urandom),
                        16'($urandom_range(0, p - 1)), 16'($urandom_range(0, p - 1)));
                end else begin
                    send_item(1'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom) % p);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        cipher_result_t want;
        cipher_result_t got;
        @(posedge rst_n);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            got = '{out_r, out_m, plain_out, public_key, status};
            @(posedge clk);
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.r !== want.r) begin
                    $error("out_r expected %0d got %0d", want.r, got.r);
                    errors++;
                end
                if (got.m !== want.m) begin
                    $error("out_m expected %0d got %0d", want.m, got.m);
                    errors++;
                end
                if (got.plain !== want.plain) begin
                    $error("plain_out expected %0d got %0d", want.plain, got.plain);
                    errors++;
                end
                if (got.pub !== want.pub) begin
                    $error("public_key expected %0d got %0d", want.pub, got.pub);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_encrypt_range();
        test_decrypt_miss();
        test_modulus_extremes();
        test_key_extremes();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
sv/emp_pkg.sv
sv/emp_modmul.sv
sv/elgamal_mod_prime_cipher.sv
test/elgamal_mod_prime_cipher_tb.sv
